// ===== design/cnsnr_pkg.sv =====
// ----------------------------------------------------------------------------
// cnsnr_pkg
// Shared types and fixed-point constants for the carrier-to-noise to
// signal-to-noise converter.
// ----------------------------------------------------------------------------
package cnsnr_pkg;

    // Raw count, offset-corrected difference and integer square root.
    typedef logic [15:0] count_t;
    typedef logic [15:0] root_t;

    // Count offset that is removed before the square root.
    localparam count_t CN_OFFSET = 16'd3000;

    // Polynomial coefficients. Each one fits in 31 unsigned bits.
    localparam logic [31:0] K_Y0 = 32'((64'd58857 << 23) / 64'd1000);
    localparam logic [30:0] K_C1 = 31'((64'd89565 << 24) / 64'd1000);
    localparam logic [30:0] K_C2 = 31'((64'd88977 << 24) / 64'd1000);
    localparam logic [30:0] K_C3 = 31'((64'd50259 << 25) / 64'd1000);
    localparam logic [30:0] K_C4 = 31'((64'd14341 << 27) / 64'd1000);
    localparam logic [30:0] K_C5 = 31'((64'd16346 << 30) / 64'd10000);

endpackage

// ===== design/cn_to_snr_sqrt_polynomial.sv =====
// ----------------------------------------------------------------------------
// cn_to_snr_sqrt_polynomial
// Converts a raw carrier-to-noise count to a signal-to-noise figure.
// ----------------------------------------------------------------------------
// Pipeline stages from an input transfer to its result: 1 offset stage,
// 8 square-root stages at two root bits each, 5 polynomial stages.
// Throughput: one count per cycle; every stage holds its item under stall
// and empty stages keep accepting while a result waits at the output.
// Reset clears all stage valid bits; the data registers are not reset.
module cn_to_snr_sqrt_polynomial
    import cnsnr_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   cn_valid,
    output logic   cn_ready,
    input  count_t cn_count,
    output logic   snr_valid,
    input  logic   snr_ready,
    output count_t snr_value
);

    logic   d_vld_reg;
    count_t d_reg;
    count_t d_next;
    logic   d_ready;
    logic   root_valid;
    logic   root_ready;
    root_t  root;

    // A count below the offset clamps to zero instead of wrapping.
    assign d_next   = (cn_count >= CN_OFFSET) ? count_t'(cn_count - CN_OFFSET) : '0;
    assign cn_ready = !d_vld_reg || d_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_vld_reg <= 1'b0;
        end
        else if (cn_ready)
        begin
            d_vld_reg <= cn_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cn_ready)
        begin
            d_reg <= d_next;
        end
    end

    cnsnr_isqrt u_isqrt (
        .clk        (clk),
        .rst_n      (rst_n),
        .d_valid    (d_vld_reg),
        .d_ready    (d_ready),
        .d          (d_reg),
        .root_valid (root_valid),
        .root_ready (root_ready),
        .root       (root)
    );

    cnsnr_poly u_poly (
        .clk        (clk),
        .rst_n      (rst_n),
        .root_valid (root_valid),
        .root_ready (root_ready),
        .root       (root),
        .snr_valid  (snr_valid),
        .snr_ready  (snr_ready),
        .snr_value  (snr_value)
    );

endmodule

// ===== design/cnsnr_isqrt.sv =====
// ----------------------------------------------------------------------------
// cnsnr_isqrt
// Pipelined floor square root of (d << 16), two root bits per stage.
// ----------------------------------------------------------------------------
module cnsnr_isqrt
    import cnsnr_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   d_valid,
    output logic   d_ready,
    input  count_t d,
    output logic   root_valid,
    input  logic   root_ready,
    output root_t  root
);

    localparam int RootW   = 16;
    localparam int BitsPer = 2;
    localparam int NSTG    = RootW / BitsPer;
    localparam int RemW    = RootW + 2;

    typedef struct packed {
        logic [RemW-1:0]  rem;
        logic [RootW-1:0] root;
    } sq_t;

    // One restoring step: bring down two radicand bits and try root*4+1.
    function automatic sq_t sqrt_step(input logic [RemW-1:0] rem,
                                      input logic [RootW-1:0] rt,
                                      input logic [1:0] pair);
        logic [RemW+1:0] cur;
        logic [RemW+1:0] trial;
        sq_t             r;
        cur   = {rem, pair};
        trial = {2'b00, rt, 2'b01};
        if (cur >= trial)
        begin
            r.rem  = RemW'(cur - trial);
            r.root = {rt[RootW-2:0], 1'b1};
        end
        else
        begin
            r.rem  = cur[RemW-1:0];
            r.root = {rt[RootW-2:0], 1'b0};
        end
        return r;
    endfunction

    logic [NSTG-1:0]  vld_reg;
    logic [NSTG-1:0]  vld_in;
    logic [NSTG-1:0]  rdy;
    logic [RemW-1:0]  rem_reg  [NSTG];
    logic [RootW-1:0] root_reg [NSTG];
    logic [31:0]      rad_reg  [NSTG];

    assign vld_in = {vld_reg[NSTG-2:0], d_valid};

    // A stage can take a new transfer when it is empty or its successor moves.
    always_comb
    begin
        rdy[NSTG-1] = !vld_reg[NSTG-1] || root_ready;
        for (int k = NSTG - 2; k >= 0; k--)
        begin
            rdy[k] = !vld_reg[k] || rdy[k+1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            for (int k = 0; k < NSTG; k++)
            begin
                if (rdy[k])
                begin
                    vld_reg[k] <= vld_in[k];
                end
            end
        end
    end

    for (genvar k = 0; k < NSTG; k++)
    begin : g_stage
        logic [RemW-1:0]  rem_in;
        logic [RootW-1:0] root_in;
        logic [31:0]      rad_in;
        sq_t              half_next;
        sq_t              step_next;

        if (k == 0)
        begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign rad_in  = {d, 16'b0};
        end
        else
        begin : g_rest
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
            assign rad_in  = rad_reg[k-1];
        end

        assign half_next = sqrt_step(rem_in, root_in, rad_in[31:30]);
        assign step_next = sqrt_step(half_next.rem, half_next.root, rad_in[29:28]);

        always_ff @(posedge clk)
        begin
            if (rdy[k])
            begin
                rem_reg[k]  <= step_next.rem;
                root_reg[k] <= step_next.root;
                rad_reg[k]  <= {rad_in[27:0], 4'b0};
            end
        end
    end

    assign d_ready    = rdy[0];
    assign root_valid = vld_reg[NSTG-1];
    assign root       = root_reg[NSTG-1];

endmodule

// ===== design/cnsnr_poly.sv =====
// ----------------------------------------------------------------------------
// cnsnr_poly
// Q31 powers of the scaled root and the fifth-order polynomial, five stages.
// ----------------------------------------------------------------------------
module cnsnr_poly
    import cnsnr_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   root_valid,
    output logic   root_ready,
    input  root_t  root,
    output logic   snr_valid,
    input  logic   snr_ready,
    output count_t snr_value
);

    localparam int NSTG = 5;

    logic [NSTG-1:0] vld_reg;
    logic [NSTG-1:0] vld_in;
    logic [NSTG-1:0] rdy;

    // The scale factor of the root is exactly 2^15, so x1 is a shift.
    logic [30:0] x1;
    assign x1 = {root, 15'b0};

    logic [30:0] x1_0_reg, x2_0_reg;
    logic [31:0] t1_0_reg;
    logic [30:0] x1_1_reg, x3_1_reg, x4_1_reg;
    logic [31:0] t2_1_reg, y_1_reg;
    logic [30:0] x5_2_reg;
    logic [31:0] t3_2_reg, t4_2_reg, y_2_reg;
    logic [31:0] t5_3_reg, y_3_reg;
    logic [31:0] y_next;
    count_t      snr_reg;

    logic [61:0] p_x2, p_t1, p_x3, p_x4, p_t2, p_x5, p_t3, p_t4, p_t5;

    assign p_x2 = 62'(x1) * 62'(x1);
    assign p_t1 = 62'(x1) * 62'(K_C1);
    assign p_x3 = 62'(x2_0_reg) * 62'(x1_0_reg);
    assign p_x4 = 62'(x2_0_reg) * 62'(x2_0_reg);
    assign p_t2 = 62'(x2_0_reg) * 62'(K_C2);
    assign p_x5 = 62'(x4_1_reg) * 62'(x1_1_reg);
    assign p_t3 = 62'(x3_1_reg) * 62'(K_C3);
    assign p_t4 = 62'(x4_1_reg) * 62'(K_C4);
    assign p_t5 = 62'(x5_2_reg) * 62'(K_C5);

    // The accumulator wraps to 32 bits after every term.
    assign y_next = y_3_reg - t5_3_reg;

    assign vld_in = {vld_reg[NSTG-2:0], root_valid};

    always_comb
    begin
        rdy[NSTG-1] = !vld_reg[NSTG-1] || snr_ready;
        for (int k = NSTG - 2; k >= 0; k--)
        begin
            rdy[k] = !vld_reg[k] || rdy[k+1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            for (int k = 0; k < NSTG; k++)
            begin
                if (rdy[k])
                begin
                    vld_reg[k] <= vld_in[k];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            x1_0_reg <= x1;
            x2_0_reg <= p_x2[61:31];
            t1_0_reg <= p_t1[61:30];
        end
        if (rdy[1])
        begin
            x1_1_reg <= x1_0_reg;
            x3_1_reg <= p_x3[61:31];
            x4_1_reg <= p_x4[61:31];
            t2_1_reg <= p_t2[59:28];
            y_1_reg  <= K_Y0 - t1_0_reg;
        end
        if (rdy[2])
        begin
            x5_2_reg <= p_x5[61:31];
            t3_2_reg <= p_t3[58:27];
            t4_2_reg <= p_t4[58:27];
            y_2_reg  <= y_1_reg + t2_1_reg;
        end
        if (rdy[3])
        begin
            t5_3_reg <= p_t5[59:28];
            y_3_reg  <= y_2_reg - t3_2_reg + t4_2_reg;
        end
        if (rdy[4])
        begin
            // A negative polynomial result reads as zero.
            snr_reg <= y_next[31] ? '0 : y_next[30:15];
        end
    end

    assign root_ready = rdy[0];
    assign snr_valid  = vld_reg[NSTG-1];
    assign snr_value  = snr_reg;

endmodule
